[src/rgb2hsv_pkg.sv]
// ----------------------------------------------------------------------------
// rgb2hsv_pkg - shared types and helpers for the RGB to HSV pixel core
// Pixel word types, pipeline stage record and one restoring divide step.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  localparam int DivSteps = 17;

  localparam logic [14:0] HueFull  = 15'd23040;
  localparam logic [14:0] HueGreen = 15'd7680;
  localparam logic [14:0] HueBlue  = 15'd15360;
  localparam logic [16:0] SatMax   = 17'd65536;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  brightness;
  } hsv_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // rem_* holds the partial remainder, sh_* shifts numerator bits out at the
  // top and quotient bits in at the bottom
  typedef struct packed {
    sector_t     sector;
    logic        neg;
    logic [7:0]  vmax;
    logic [7:0]  delta;
    logic [7:0]  rem_h;
    logic [16:0] sh_h;
    logic [7:0]  rem_s;
    logic [16:0] sh_s;
  } stage_t;

  // one quotient bit for both the hue and the saturation divide
  function automatic stage_t div_stage(stage_t s);
    stage_t     o;
    logic [8:0] th;
    logic [8:0] ts;
    o  = s;
    th = {s.rem_h, s.sh_h[16]};
    if (th >= {1'b0, s.delta}) begin
      th     = th - {1'b0, s.delta};
      o.sh_h = {s.sh_h[15:0], 1'b1};
    end else begin
      o.sh_h = {s.sh_h[15:0], 1'b0};
    end
    o.rem_h = th[7:0];
    ts = {s.rem_s, s.sh_s[16]};
    if (ts >= {1'b0, s.vmax}) begin
      ts     = ts - {1'b0, s.vmax};
      o.sh_s = {s.sh_s[15:0], 1'b1};
    end else begin
      o.sh_s = {s.sh_s[15:0], 1'b0};
    end
    o.rem_s = ts[7:0];
    return o;
  endfunction

endpackage

[src/rgb_to_hsv_pixel_core.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core - streaming 8-bit RGB to fixed point HSV converter
// Max/min front end, 17 stage restoring divider, hue assembly, output skid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rgb/rgb_valid/rgb_stall carries one RGB pixel per word.
//   Output channel hsv/hsv_valid/hsv_stall carries hue in 1/64 degree
//   (0..23039), saturation scaled by 65536 and brightness (largest byte).
//   A word moves at a rising edge with valid high and stall low.
// Throughput: one pixel per cycle while rgb_stall is low. Both divides advance
//   one quotient bit per pipeline stage, 17 stages, so the stage count sets the
//   latency.
// Stall: the output register holds while hsv_stall is high; one more word
//   drops into a skid register, then rgb_stall rises and the whole pipeline
//   freezes until the skid word is taken. Nothing is dropped or repeated.
// Reset: synchronous, clears all valid bits and the skid; no words are in
//   flight afterwards and the block accepts input in the next cycle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              rgb_valid,
  output logic              rgb_stall,
  input  rgb2hsv_pkg::rgb_t rgb,
  output logic              hsv_valid,
  input  logic              hsv_stall,
  output rgb2hsv_pkg::hsv_t hsv
);

  localparam int NumStg = rgb2hsv_pkg::DivSteps + 1;

  logic                  en;
  logic [NumStg-1:0]     vld;
  rgb2hsv_pkg::stage_t   stg [NumStg];
  rgb2hsv_pkg::stage_t   front;
  rgb2hsv_pkg::stage_t   last;
  rgb2hsv_pkg::sector_t  sector;
  rgb2hsv_pkg::hsv_t     res;
  rgb2hsv_pkg::hsv_t     skid;
  logic                  skid_full;
  logic [7:0]            vmax;
  logic [7:0]            vmin;
  logic [7:0]            delta;
  logic [8:0]            diff;
  logic [7:0]            mag;
  logic [19:0]           num_h;
  logic [11:0]           qh;
  logic [12:0]           qh_up;
  logic [14:0]           off;

  assign en        = !skid_full;
  assign rgb_stall = skid_full;

  // front end: max, min, sector, hue and saturation numerators
  always_comb begin
    vmax = rgb.red;
    if (rgb.green > vmax) vmax = rgb.green;
    if (rgb.blue > vmax) vmax = rgb.blue;
    vmin = rgb.red;
    if (rgb.green < vmin) vmin = rgb.green;
    if (rgb.blue < vmin) vmin = rgb.blue;
    delta = vmax - vmin;
    if (vmax == rgb.red) begin
      sector = rgb2hsv_pkg::SEC_RED;
      diff   = {1'b0, rgb.green} - {1'b0, rgb.blue};
    end else if (vmax == rgb.green) begin
      sector = rgb2hsv_pkg::SEC_GREEN;
      diff   = {1'b0, rgb.blue} - {1'b0, rgb.red};
    end else begin
      sector = rgb2hsv_pkg::SEC_BLUE;
      diff   = {1'b0, rgb.red} - {1'b0, rgb.green};
    end
    mag   = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
    num_h = ({12'd0, mag} << 12) - ({12'd0, mag} << 8);  // mag * 3840
    front.sector = sector;
    front.neg    = diff[8];
    front.vmax   = vmax;
    front.delta  = delta;
    front.rem_h  = {5'd0, num_h[19:17]};
    front.sh_h   = num_h[16:0];
    front.rem_s  = {1'b0, delta[7:1]};
    front.sh_s   = {delta[0], 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStg-2:0], rgb_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= front;
    end
  end

  for (genvar k = 1; k < NumStg; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= rgb2hsv_pkg::div_stage(stg[k-1]);
      end
    end
  end

  // hue assembly; floor of a negative term rounds the magnitude up
  assign last = stg[NumStg-1];

  always_comb begin
    qh    = last.sh_h[11:0];
    qh_up = {1'b0, qh} + {12'd0, (last.rem_h != 8'd0)};
    unique case (last.sector)
      rgb2hsv_pkg::SEC_RED:   off = last.neg ? rgb2hsv_pkg::HueFull : 15'd0;
      rgb2hsv_pkg::SEC_GREEN: off = rgb2hsv_pkg::HueGreen;
      rgb2hsv_pkg::SEC_BLUE:  off = rgb2hsv_pkg::HueBlue;
      default:                off = 15'd0;
    endcase
    if (last.delta == 8'd0) begin
      res.hue = 15'd0;
    end else if (last.neg) begin
      res.hue = off - {2'd0, qh_up};
    end else begin
      res.hue = off + {3'd0, qh};
    end
    res.saturation = (last.vmax == 8'd0) ? 17'd0 : last.sh_s;
    res.brightness = last.vmax;
  end

  // output register plus one word of skid
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!hsv_stall) begin
        skid_full <= 1'b0;
      end
    end else if (!hsv_valid || !hsv_stall) begin
      hsv_valid <= vld[NumStg-1];
    end else if (vld[NumStg-1]) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!hsv_stall) begin
        hsv <= skid;
      end
    end else if (!hsv_valid || !hsv_stall) begin
      hsv <= res;
    end
    if (!skid_full && hsv_valid && hsv_stall) begin
      skid <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(hsv_valid && hsv_stall))
    else $error("skid filled without a stalled output word");

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> hsv_valid)
    else $error("skid holds a word while output is empty");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue < rgb2hsv_pkg::HueFull)
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.saturation <= rgb2hsv_pkg::SatMax)
    else $error("saturation out of range");

  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.brightness == 8'd0 |-> hsv.saturation == 17'd0 && hsv.hue == 15'd0)
    else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
